// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is applied.
`define HPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hpt assertion failed");

// Clocked assertion that also holds while reset is applied.
`define HPT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("hpt assertion failed");

`endif

// ===== rtl/core/hpt_pkg.sv =====
// Types and constants shared by the homogeneous point transform modules.
package hpt_pkg;

  localparam int unsigned COMP_W      = 32;
  localparam int unsigned REG_W       = 64;
  localparam int unsigned NUM_REGS    = 8;
  localparam int unsigned REG_IDX_W   = 3;
  localparam int unsigned DATA_W      = 3 * COMP_W;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [NUM_REGS-1:0][REG_W-1:0] mat_t;

  localparam logic OP_POINT = 1'b0;
  localparam logic OP_DIR   = 1'b1;

  localparam comp_t COMP_MAX = 32'sh7fff_ffff;
  localparam comp_t COMP_MIN = 32'sh8000_0000;

  // Identity matrix in Q16.16, register 7 first.
  localparam mat_t MAT_RESET = {
    64'h0001_0000_0000_0000, 64'h0,
    64'h0000_0000_0001_0000, 64'h0,
    64'h0,                   64'h0001_0000_0000_0000,
    64'h0,                   64'h0000_0000_0001_0000
  };

  // Classified item handed from the front end to the divide back end.
  typedef struct packed {
    logic  bypass;
    logic  flag;
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
  } queue_item_t;

endpackage

// ===== rtl/core/hpt_queue.sv =====
// Small FIFO between the transform front end and the divide back end.
module hpt_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hpt_pkg::queue_item_t item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output hpt_pkg::queue_item_t item_o
);
  import hpt_pkg::*;

  queue_item_t       mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/core/hpt_front.sv =====
// Front end: accept vectors, multiply by the matrix, form rows, clamp, classify.
module hpt_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic                 op_i,
  input  hpt_pkg::comp_t       x_i,
  input  hpt_pkg::comp_t       y_i,
  input  hpt_pkg::comp_t       z_i,
  input  hpt_pkg::mat_t        mat_i,
  input  logic                 full_i,
  output logic                 push_o,
  output hpt_pkg::queue_item_t item_o
);
  import hpt_pkg::*;

  localparam int unsigned SUM_W = 68;
  localparam comp_t ONE = comp_t'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [SUM_W-1:0] LIM_HI = SUM_W'(COMP_MAX);
  localparam logic signed [SUM_W-1:0] LIM_LO = SUM_W'(COMP_MIN);

  comp_t                   elem [4][4];
  logic                    en;
  logic                    v1_q, v2_q, v3_q;
  logic                    op1_q, op2_q;
  comp_t                   vec1_q [3];
  logic signed [2*COMP_W-1:0] prod_q [4][3];
  logic signed [SUM_W-1:0] tot [4];
  comp_t                   cl [4];
  logic [3:0]              sat;
  queue_item_t             item_d, item_q;

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign elem[r][c] = mat_i[r*2 + c/2][(c%2)*COMP_W +: COMP_W];
    end
  end

  // Whole front advances unless the finished item cannot enter the queue.
  assign en      = !v3_q || !full_i;
  assign ready_o = en;
  assign push_o  = v3_q && !full_i;
  assign item_o  = item_q;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      tot[r] = ((SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1]) + SUM_W'(prod_q[r][2]))
               >>> FRAC_BITS)
             + ((op2_q == OP_POINT) ? SUM_W'(elem[r][3]) : SUM_W'(0));
      if (tot[r] > LIM_HI) begin
        cl[r]  = COMP_MAX;
        sat[r] = 1'b1;
      end else if (tot[r] < LIM_LO) begin
        cl[r]  = COMP_MIN;
        sat[r] = 1'b1;
      end else begin
        cl[r]  = tot[r][COMP_W-1:0];
        sat[r] = 1'b0;
      end
    end
    item_d.bypass = (op2_q == OP_DIR) || (cl[3] == '0) || (cl[3] == ONE);
    item_d.flag   = sat[0] || sat[1] || sat[2] || ((op2_q == OP_POINT) && sat[3]);
    item_d.x      = cl[0];
    item_d.y      = cl[1];
    item_d.z      = cl[2];
    item_d.w      = cl[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q     <= op_i;
      vec1_q[0] <= x_i;
      vec1_q[1] <= y_i;
      vec1_q[2] <= z_i;
      op2_q     <= op1_q;
      for (int r = 0; r < 4; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[r][k] <= elem[r][k] * vec1_q[k];
        end
      end
      item_q <= item_d;
    end
  end

endmodule

// ===== rtl/core/hpt_back.sv =====
// Back end: pipelined radix-2 divide by w, saturation and output register.
module hpt_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  hpt_pkg::queue_item_t item_i,
  output logic                 pop_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output hpt_pkg::comp_t       x_o,
  output hpt_pkg::comp_t       y_o,
  output hpt_pkg::comp_t       z_o,
  output logic                 sat_o
);
  import hpt_pkg::*;

  localparam int unsigned DW = COMP_W + FRAC_BITS;
  localparam logic [DW-1:0] MAG_NEG = {{(DW-COMP_W){1'b0}}, 32'h8000_0000};
  localparam logic [DW-1:0] MAG_POS = {{(DW-COMP_W){1'b0}}, 32'h7fff_ffff};

  typedef struct packed {
    logic                         byp;
    logic                         flag;
    logic [2:0]                   neg;
    logic [COMP_W-1:0]            dmag;
    logic [2:0][DW-1:0]           num;
    logic [2:0][COMP_W-1:0]       rem;
    logic [2:0][COMP_W-1:0]       pass;
  } div_stage_t;

  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t        n;
    logic [COMP_W:0]   r33;
    logic              ge;
    n = s;
    for (int l = 0; l < 3; l++) begin
      r33      = {s.rem[l], s.num[l][DW-1]};
      ge       = (r33 >= {1'b0, s.dmag});
      n.rem[l] = ge ? COMP_W'(r33 - {1'b0, s.dmag}) : r33[COMP_W-1:0];
      n.num[l] = {s.num[l][DW-2:0], ge};
    end
    return n;
  endfunction

  logic        en;
  logic        vld_q [DW+1];
  div_stage_t  st_q  [DW+1];
  div_stage_t  ld;
  comp_t       rv [3];
  comp_t       res [3];
  logic [2:0]  qsat;
  logic        flag_d;
  logic        out_v_q;
  comp_t       out_q [3];
  logic        sat_q;

  // Divide pipe and output register stall together when the result is held.
  assign en    = !out_v_q || ready_i;
  assign pop_o = en && valid_i;

  assign rv[0] = item_i.x;
  assign rv[1] = item_i.y;
  assign rv[2] = item_i.z;

  always_comb begin
    ld.byp  = item_i.bypass;
    ld.flag = item_i.flag;
    ld.dmag = item_i.w[COMP_W-1] ? COMP_W'(~item_i.w + 1'b1) : COMP_W'(item_i.w);
    for (int l = 0; l < 3; l++) begin
      ld.neg[l]  = rv[l][COMP_W-1] ^ item_i.w[COMP_W-1];
      ld.num[l]  = {(rv[l][COMP_W-1] ? COMP_W'(~rv[l] + 1'b1) : COMP_W'(rv[l])),
                    {FRAC_BITS{1'b0}}};
      ld.rem[l]  = '0;
      ld.pass[l] = rv[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= ld;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k+1] <= div_step(st_q[k]);
      end
    end
  end

  // Pass bypassed values through; else apply sign to the quotient magnitude and clamp to 32 bits.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (st_q[DW].byp) begin
        res[l]  = st_q[DW].pass[l];
        qsat[l] = 1'b0;
      end else if (st_q[DW].neg[l]) begin
        qsat[l] = (st_q[DW].num[l] > MAG_NEG);
        res[l]  = qsat[l] ? COMP_MIN : comp_t'(~st_q[DW].num[l][COMP_W-1:0] + 1'b1);
      end else begin
        qsat[l] = (st_q[DW].num[l] > MAG_POS);
        res[l]  = qsat[l] ? COMP_MAX : comp_t'(st_q[DW].num[l][COMP_W-1:0]);
      end
    end
    flag_d = st_q[DW].flag || (|qsat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= vld_q[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q[0] <= res[0];
      out_q[1] <= res[1];
      out_q[2] <= res[2];
      sat_q    <= flag_d;
    end
  end

  assign valid_o = out_v_q;
  assign x_o     = out_q[0];
  assign y_o     = out_q[1];
  assign z_o     = out_q[2];
  assign sat_o   = sat_q;

endmodule

// ===== rtl/core/homogeneous_point_transform.sv =====
// Top level of the homogeneous point transform: matrix registers and the stream pipeline.
//
// Transforms one signed fixed-point 3-D vector (FRAC_BITS fraction bits, Q16.16 by
// default) by a 4x4 matrix held in eight 64-bit registers, one vector per clock cycle
// sustained while the output is not held back. Point transfers (tuser = 0) add the
// translation column, form w from row 3 and divide x, y and z by w (truncating toward
// zero) unless w is exactly 0 or 1.0; direction transfers (tuser = 1) use the 3x3 part
// only. Any x, y or z value clipped to the 32-bit range, or a clipped point w, raises
// the output tuser flag. An input transfer passes through the registered multiply
// front end, the queue and the back end, whose divider resolves one quotient bit per
// pipeline stage. The four-entry queue lets the front end keep taking transfers while
// a result waits on the output. Reset loads the identity matrix; write the matrix only
// while the block is empty.
module homogeneous_point_transform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Matrix register writes.
  input  logic                           cfg_we_i,
  input  logic [hpt_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hpt_pkg::REG_W-1:0]      cfg_data_i,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [hpt_pkg::DATA_W-1:0]     s_axis_tdata,  // in_x, in_y, in_z
  input  logic                           s_axis_tuser,  // op
  // Output stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [hpt_pkg::DATA_W-1:0]     m_axis_tdata,  // out_x, out_y, out_z
  output logic                           m_axis_tuser   // saturated
);
  import hpt_pkg::*;

  mat_t        mat_q;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_valid;
  queue_item_t q_in;
  queue_item_t q_out;
  comp_t       res_x, res_y, res_z;

  // Matrix registers: reset to identity, written by index with no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= MAT_RESET;
    end else if (cfg_we_i) begin
      mat_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Front end: take the transfer, multiply, sum rows, clamp and classify.
  hpt_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s_axis_tvalid),
    .ready_o(s_axis_tready),
    .op_i   (s_axis_tuser),
    .x_i    (comp_t'(s_axis_tdata[COMP_W-1:0])),
    .y_i    (comp_t'(s_axis_tdata[2*COMP_W-1:COMP_W])),
    .z_i    (comp_t'(s_axis_tdata[3*COMP_W-1:2*COMP_W])),
    .mat_i  (mat_q),
    .full_i (q_full),
    .push_o (q_push),
    .item_o (q_in)
  );

  // Decouple the front end from the divide back end.
  hpt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (q_out)
  );

  // Back end: divide by w where needed and hold the result for the sink.
  hpt_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(q_valid),
    .item_i (q_out),
    .pop_o  (q_pop),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .x_o    (res_x),
    .y_o    (res_y),
    .z_o    (res_z),
    .sat_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {res_z, res_y, res_x};

endmodule

// ===== rtl/core/hpt_checker.sv =====
// Port-level assertions for the homogeneous point transform, bound to the top level.
`include "assert_macros.svh"

module hpt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [hpt_pkg::DATA_W-1:0]  m_axis_tdata,
  input logic                        m_axis_tuser
);
  logic [7:0] cnt_q, cnt_d;
  logic       in_xfer, out_xfer;
  logic       out_hold;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign out_hold = m_axis_tvalid && !m_axis_tready;

  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer && !out_xfer) begin
      cnt_d = cnt_q + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `HPT_ASSERT(a_out_valid_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
  `HPT_ASSERT(a_out_data_holds, out_hold |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `HPT_ASSERT(a_no_invented_result, m_axis_tvalid |-> cnt_q != 8'd0)
  `HPT_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !m_axis_tvalid)

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (.*);

// ===== verif/homogeneous_point_transform_test.sv =====
// Self-checking stream testbench for the homogeneous point transform.
`timescale 1ns / 100ps

module homogeneous_point_transform_test;
  import hpt_pkg::*;

  localparam int unsigned FRAC      = 16;
  localparam int unsigned MAX_CYCLE = 2_000_000;
  localparam int unsigned DRAIN     = 200;
  localparam int unsigned PHASES    = 8;
  localparam int unsigned PER_PHASE = 244;

  // Register indexes, in the order of the matrix layout.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW0_C01, REG_ROW0_C23, REG_ROW1_C01, REG_ROW1_C23,
    REG_ROW2_C01, REG_ROW2_C23, REG_ROW3_C01, REG_ROW3_C23
  } reg_idx_e;

  // Matrix fill styles used from phase to phase.
  typedef enum int {
    MAT_IDENTITY, MAT_SMALL, MAT_FULL, MAT_ALL_MAX, MAT_ALL_MIN, MAT_PERSPECTIVE,
    MAT_ZERO_W, MAT_MIXED
  } mat_style_e;

  typedef struct packed {
    logic  op;
    comp_t x;
    comp_t y;
    comp_t z;
  } vec_item_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    logic  sat;
  } vec_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_idx_i;
  logic [REG_W-1:0]     cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata;  // in_x, in_y, in_z
  logic                 s_axis_tuser;  // op
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [DATA_W-1:0]    m_axis_tdata;  // out_x, out_y, out_z
  logic                 m_axis_tuser;  // saturated

  homogeneous_point_transform #(.FRAC_BITS(FRAC)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Our copy of the matrix, element [row][col]; follows every register write.
  comp_t       mat_model [4][4];
  vec_item_t   pending_vecs[$];
  vec_result_t expected_vecs[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  // Cleared during some phases to give stretches without idling.
  bit          src_idle_on = 1'b1;
  bit          snk_idle_on = 1'b1;

  // Clamp a wide signed value to 32 bits and note when it clips.
  function automatic logic signed [63:0] clamp_comp(input logic signed [79:0] v,
                                                    inout logic sat);
    if (v > 80'(signed'(COMP_MAX))) begin
      sat = 1'b1;
      return 64'(signed'(COMP_MAX));
    end
    if (v < 80'(signed'(COMP_MIN))) begin
      sat = 1'b1;
      return 64'(signed'(COMP_MIN));
    end
    return v[63:0];
  endfunction

  // Expected output of one vector under the current matrix.
  function automatic vec_result_t transform_vec(input vec_item_t it);
    logic signed [79:0] acc;
    logic signed [79:0] a;
    logic signed [79:0] b;
    logic signed [79:0] q;
    logic signed [63:0] c [4];
    comp_t              v [3];
    logic               sat;
    logic               point;
    vec_result_t        res;
    sat   = 1'b0;
    point = (it.op == OP_POINT);
    v[0]  = it.x;
    v[1]  = it.y;
    v[2]  = it.z;
    for (int r = 0; r < 4; r++) begin
      c[r] = '0;
      if (r < 3 || point) begin
        acc = '0;
        for (int k = 0; k < 3; k++) begin
          a = mat_model[r][k];
          b = v[k];
          acc = acc + a * b;
        end
        // Floor of the exact sum, then the translation column in point mode.
        acc = acc >>> FRAC;
        if (point) begin
          a = mat_model[r][3];
          acc = acc + a;
        end
        c[r] = clamp_comp(acc, sat);
      end
    end
    // In point mode, divide unless w is exactly zero or exactly one.
    if (point && c[3] != 0 && c[3] != (64'sd1 <<< FRAC)) begin
      for (int i = 0; i < 3; i++) begin
        a = c[i];
        b = c[3];
        q = (a <<< FRAC) / b;
        c[i] = clamp_comp(q, sat);
      end
    end
    res.x   = c[0][31:0];
    res.y   = c[1][31:0];
    res.z   = c[2][31:0];
    res.sat = sat;
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned next_gap(input bit enabled);
    int unsigned pick;
    if (!enabled) return 0;
    pick = $urandom_range(0, 19);
    if (pick < 12) return 0;
    if (pick < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 9))
      0: return COMP_MAX;
      1: return COMP_MIN;
      2: return '0;
      3: return comp_t'($signed($urandom_range(0, 16)) - 8) <<< FRAC;
      4, 5: return comp_t'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic comp_t rand_elem(input mat_style_e style);
    case (style)
      MAT_SMALL, MAT_PERSPECTIVE:
        return comp_t'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      MAT_ALL_MAX: return COMP_MAX;
      MAT_ALL_MIN: return COMP_MIN;
      MAT_MIXED:   return rand_comp();
      default:     return comp_t'($urandom);
    endcase
  endfunction

  // Input driver: present the queue head, hold it until the transfer, then idle for a random gap that may be zero.
  int unsigned src_gap = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_vecs.push_back(transform_vec(pending_vecs.pop_front()));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_vecs.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= pending_vecs[0].op;
          s_axis_tdata  <= {pending_vecs[0].z, pending_vecs[0].y, pending_vecs[0].x};
          src_gap = next_gap(src_idle_on);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compare each transfer with the oldest expectation.
  int unsigned snk_gap = 0;
  always @(posedge clk_i) begin
    vec_result_t got;
    vec_result_t exp_res;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.x   = m_axis_tdata[31:0];
        got.y   = m_axis_tdata[63:32];
        got.z   = m_axis_tdata[95:64];
        got.sat = m_axis_tuser;
        if (expected_vecs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output transfer: x=%h y=%h z=%h sat=%b",
                     got.x, got.y, got.z, got.sat);
        end else begin
          exp_res = expected_vecs.pop_front();
          if (got !== exp_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected x=%h y=%h z=%h sat=%b, got x=%h y=%h z=%h sat=%b",
                       exp_res.x, exp_res.y, exp_res.z, exp_res.sat,
                       got.x, got.y, got.z, got.sat);
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        snk_gap = next_gap(snk_idle_on);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLE) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Wait until the pipeline is empty, then let it settle.
  task automatic wait_idle();
    while (pending_vecs.size() > 0 || expected_vecs.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // Write all eight registers from a full matrix and update the model.
  task automatic load_matrix(input comp_t mm [4][4]);
    reg_idx_e idx;
    int       r;
    int       c;
    idx = idx.first();
    for (int i = 0; i < NUM_REGS; i++) begin
      r = i / 2;
      c = (i % 2) * 2;
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= {mm[r][c+1], mm[r][c]};
      mat_model[r][c]   = mm[r][c];
      mat_model[r][c+1] = mm[r][c+1];
      idx = idx.next();
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_vec(input logic op, input comp_t x, input comp_t y, input comp_t z);
    vec_item_t it;
    it.op = op;
    it.x  = x;
    it.y  = y;
    it.z  = z;
    pending_vecs.push_back(it);
  endtask

  initial begin
    comp_t      mm [4][4];
    mat_style_e style;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_POINT;
    m_axis_tready = 1'b0;
    // Reset leaves the identity matrix.
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        mat_model[r][c] = (r == c) ? comp_t'(1 << FRAC) : '0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes under the reset identity, both operations (w is 1.0).
    push_vec(OP_POINT, COMP_MAX, COMP_MIN, '0);
    push_vec(OP_DIR,   COMP_MAX, COMP_MIN, '0);
    push_vec(OP_POINT, COMP_MIN, COMP_MAX, comp_t'(-1));
    push_vec(OP_DIR,   comp_t'(-1), comp_t'(1), COMP_MAX);
    push_vec(OP_POINT, comp_t'(1 << FRAC), comp_t'(-(1 << FRAC)), comp_t'(3));
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      style = mat_style_e'(ph);
      src_idle_on = (ph != 2);
      snk_idle_on = (ph != 3);
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          mm[r][c] = (style == MAT_IDENTITY) ? ((r == c) ? comp_t'(1 << FRAC) : '0)
                                             : rand_elem(style);
      if (style == MAT_PERSPECTIVE) begin
        // w follows x alone, so chosen x values hit w of zero and one.
        mm[3][0] = comp_t'(1 << FRAC);
        mm[3][1] = '0;
        mm[3][2] = '0;
        mm[3][3] = '0;
      end
      if (style == MAT_ZERO_W)
        for (int c = 0; c < 4; c++) mm[3][c] = '0;
      load_matrix(mm);

      if (style == MAT_PERSPECTIVE) begin
        push_vec(OP_POINT, '0, comp_t'(5 << FRAC), comp_t'(-3 << FRAC));
        push_vec(OP_POINT, comp_t'(1 << FRAC), COMP_MAX, COMP_MIN);
        push_vec(OP_POINT, comp_t'(-1), COMP_MAX, COMP_MAX);
        push_vec(OP_POINT, comp_t'(1), COMP_MIN, COMP_MIN);
        push_vec(OP_DIR,   '0, COMP_MAX, COMP_MIN);
      end
      if (style == MAT_ALL_MAX || style == MAT_ALL_MIN) begin
        push_vec(OP_POINT, COMP_MAX, COMP_MAX, COMP_MAX);
        push_vec(OP_POINT, COMP_MIN, COMP_MIN, COMP_MIN);
        push_vec(OP_DIR,   COMP_MIN, COMP_MAX, COMP_MIN);
      end
      for (int n = 0; n < PER_PHASE; n++)
        push_vec(logic'($urandom_range(0, 1)), rand_comp(), rand_comp(), rand_comp());
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/hpt_pkg.sv
rtl/core/hpt_queue.sv
rtl/core/hpt_front.sv
rtl/core/hpt_back.sv
rtl/core/homogeneous_point_transform.sv
rtl/core/hpt_checker.sv
verif/homogeneous_point_transform_test.sv
